>>> src/dop_pkg.sv
// ----------------------------------------------------------------------------
// dop_pkg
// Shared types and constants for the DHCP options parser.
// ----------------------------------------------------------------------------
package dop_pkg;

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_COOKIE = 3'd1;
  localparam logic [2:0] PH_CODE   = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_COOKIE = 2'd1;
  localparam logic [1:0] ST_NOEND  = 2'd2;

  localparam logic [7:0] CODE_PAD     = 8'd0;
  localparam logic [7:0] CODE_MASK    = 8'd1;
  localparam logic [7:0] CODE_GATEWAY = 8'd3;
  localparam logic [7:0] CODE_DNS     = 8'd6;
  localparam logic [7:0] CODE_END     = 8'd255;

  localparam int unsigned OUT_TDATA_W = 104;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } dop_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_addr;
    logic [31:0] dns_addr;
    logic [2:0]  seen_bits;
  } dop_result_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'd99;
      2'd1:    val = 8'd130;
      2'd2:    val = 8'd83;
      default: val = 8'd99;
    endcase
    return val;
  endfunction

endpackage

>>> src/dop_parse.sv
// ----------------------------------------------------------------------------
// dop_parse
// Per-byte parse state machine and captured address registers.
// ----------------------------------------------------------------------------
module dop_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  dop_pkg::dop_item_t   item,
  output logic                 emit,
  output dop_pkg::dop_result_t result
);
  import dop_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  cookie_pos_r, cookie_pos_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [2:0]  dpos_r, dpos_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] gw_r, gw_nxt;
  logic [31:0] dns_r, dns_nxt;
  logic [2:0]  seen_r, seen_nxt;

  logic [2:0]  phase_e;
  logic [1:0]  cookie_pos_e;
  logic [7:0]  code_e;
  logic [7:0]  left_e;
  logic [2:0]  dpos_e;
  logic [31:0] gather_e;
  logic [2:0]  seen_e;
  logic        commit;
  logic        done_early;
  logic [1:0]  status;
  logic [7:0]  b;

  always_comb begin
    b = item.data_byte;
    // a first byte restarts from a clean record state
    phase_e      = item.first_byte ? PH_COOKIE : phase_r;
    cookie_pos_e = item.first_byte ? 2'd0 : cookie_pos_r;
    code_e       = item.first_byte ? 8'd0 : code_r;
    left_e       = item.first_byte ? 8'd0 : left_r;
    dpos_e       = item.first_byte ? 3'd0 : dpos_r;
    gather_e     = item.first_byte ? 32'd0 : gather_r;
    seen_e       = item.first_byte ? 3'd0 : seen_r;

    phase_nxt      = phase_e;
    cookie_pos_nxt = cookie_pos_e;
    code_nxt       = code_e;
    left_nxt       = left_e;
    dpos_nxt       = dpos_e;
    gather_nxt     = gather_e;
    commit         = 1'b0;
    done_early     = 1'b0;
    status         = ST_OK;

    case (phase_e)
      PH_COOKIE: begin
        if (b != cookie_byte(cookie_pos_e)) begin
          done_early = 1'b1;
          status     = ST_COOKIE;
        end else if (cookie_pos_e == 2'd3) begin
          phase_nxt = PH_CODE;
        end else begin
          cookie_pos_nxt = cookie_pos_e + 2'd1;
        end
      end
      PH_CODE: begin
        if (b == CODE_END) begin
          done_early = 1'b1;
          status     = ST_OK;
        end else if (b != CODE_PAD) begin
          code_nxt  = b;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        left_nxt   = b;
        dpos_nxt   = 3'd0;
        gather_nxt = 32'd0;
        if (b == 8'd0) begin
          commit    = 1'b1;
          phase_nxt = PH_CODE;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!dpos_e[2]) begin
          case (dpos_e[1:0])
            2'd0:    gather_nxt = gather_e | {b, 24'd0};
            2'd1:    gather_nxt = gather_e | {8'd0, b, 16'd0};
            2'd2:    gather_nxt = gather_e | {16'd0, b, 8'd0};
            default: gather_nxt = gather_e | {24'd0, b};
          endcase
          dpos_nxt = dpos_e + 3'd1;
        end
        left_nxt = left_e - 8'd1;
        if (left_nxt == 8'd0) begin
          commit    = 1'b1;
          phase_nxt = PH_CODE;
        end
      end
      default: ;
    endcase

    mask_nxt = mask_r;
    gw_nxt   = gw_r;
    dns_nxt  = dns_r;
    seen_nxt = seen_e;
    if (commit) begin
      case (code_nxt)
        CODE_MASK: begin
          mask_nxt    = gather_nxt;
          seen_nxt[0] = 1'b1;
        end
        CODE_GATEWAY: begin
          gw_nxt      = gather_nxt;
          seen_nxt[1] = 1'b1;
        end
        CODE_DNS: begin
          dns_nxt     = gather_nxt;
          seen_nxt[2] = 1'b1;
        end
        default: ;
      endcase
    end

    // emit on an end code or a bad cookie, or when the area buffer ran out before an end code
    emit = 1'b0;
    if (done_early) begin
      emit = 1'b1;
    end else if (item.last_byte && phase_e != PH_DONE) begin
      emit   = 1'b1;
      status = ST_NOEND;
    end
    if (emit) begin
      phase_nxt = PH_DONE;
    end

    result.status       = status;
    result.subnet_mask  = mask_nxt;
    result.gateway_addr = gw_nxt;
    result.dns_addr     = dns_nxt;
    result.seen_bits    = seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DONE;
      cookie_pos_r <= 2'd0;
      code_r       <= 8'd0;
      left_r       <= 8'd0;
      dpos_r       <= 3'd0;
      gather_r     <= 32'd0;
      mask_r       <= 32'd0;
      gw_r         <= 32'd0;
      dns_r        <= 32'd0;
      seen_r       <= 3'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      cookie_pos_r <= cookie_pos_nxt;
      code_r       <= code_nxt;
      left_r       <= left_nxt;
      dpos_r       <= dpos_nxt;
      gather_r     <= gather_nxt;
      mask_r       <= mask_nxt;
      gw_r         <= gw_nxt;
      dns_r        <= dns_nxt;
      seen_r       <= seen_nxt;
    end
  end

endmodule

>>> src/dhcp_option_parser.sv
// ----------------------------------------------------------------------------
// dhcp_option_parser
// Parses the DHCP options area byte by byte and reports mask, gateway, DNS.
// ----------------------------------------------------------------------------
// channel | direction | tdata                      | tuser      | tlast
// in_     | slave     | data_byte                  | first_byte | last_byte
// out_    | master     | mask, gateway, dns, seen   | status     | -
//
// one byte per cycle sustained while out_ is not stalled; a byte is parsed
// out of the input register, its result registered in the result register.
// the parse state machine and the single result register set the rate.
// reset clears the parse state and the captured addresses.
// a stalled result holds the parser; the input register takes a byte only if empty.
// ----------------------------------------------------------------------------
module dhcp_option_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] first_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [31:0] subnet_mask, [63:32] gateway_addr,
                                   // [95:64] dns_addr, [98:96] seen_bits
  output logic [1:0]   out_tuser   // [1:0] status
);
  import dop_pkg::*;

  logic        in_valid_r;
  dop_item_t   in_item_r;
  logic        out_valid_r;
  dop_result_t out_res_r;
  logic        advance;
  logic        emit;
  dop_result_t result;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.data_byte  <= in_tdata;
      in_item_r.first_byte <= in_tuser;
      in_item_r.last_byte  <= in_tlast;
    end
  end

  dop_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'd0, out_res_r.seen_bits, out_res_r.dns_addr,
                       out_res_r.gateway_addr, out_res_r.subnet_mask};

endmodule

>>> tb/dhcp_option_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_parser_tb
// Streams option areas (good, truncated, restarted, bad cookie and stray
// bytes) through the parser under varying backpressure and checks every
// status and captured address against a behavioral model of the parser.
// ----------------------------------------------------------------------------
module dhcp_option_parser_tb;
  import dop_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 385;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;

  dhcp_option_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // bytes waiting to be sent and parse results still to come
  dop_item_t   option_bytes_q[$];
  dop_result_t parse_outcomes[$];
  dop_item_t   next_byte;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_phase = 1'b0;
  bit hold_on = 1'b0;
  bit in_taken = 1'b0;
  int fail_count = 0;
  int bytes_queued = 0;
  int cycle_count = 0;

  // parser shadow state
  logic [7:0]  magic [4] = '{8'd99, 8'd130, 8'd83, 8'd99};
  logic [2:0]  ph = PH_DONE;
  logic [1:0]  ck_pos = 2'd0;
  logic [7:0]  opt_code = 8'd0;
  logic [7:0]  data_left = 8'd0;
  logic [2:0]  data_idx = 3'd0;
  logic [31:0] gather = 32'd0;
  logic [31:0] mask_val = 32'd0;
  logic [31:0] gw_val = 32'd0;
  logic [31:0] dns_val = 32'd0;
  logic [2:0]  seen = 3'd0;

  function automatic void put_byte(input logic [7:0] b, input logic f, input logic l);
    dop_item_t it;
    it.data_byte  = b;
    it.first_byte = f;
    it.last_byte  = l;
    option_bytes_q.push_back(it);
    bytes_queued++;
  endfunction

  function automatic void store_option();
    case (opt_code)
      CODE_MASK: begin
        mask_val = gather;
        seen[0] = 1'b1;
      end
      CODE_GATEWAY: begin
        gw_val = gather;
        seen[1] = 1'b1;
      end
      CODE_DNS: begin
        dns_val = gather;
        seen[2] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_outcome(input logic [1:0] st);
    dop_result_t r;
    r.status       = st;
    r.subnet_mask  = mask_val;
    r.gateway_addr = gw_val;
    r.dns_addr     = dns_val;
    r.seen_bits    = seen;
    parse_outcomes.push_back(r);
    ph = PH_DONE;
  endfunction

  function automatic void follow_parser_byte(input logic [7:0] b, input logic f,
                                             input logic l);
    bit ended;
    ended = 1'b0;
    if (f) begin
      ph        = PH_COOKIE;
      ck_pos    = 2'd0;
      opt_code  = 8'd0;
      data_left = 8'd0;
      data_idx  = 3'd0;
      gather    = 32'd0;
      seen      = 3'd0;
    end
    case (ph)
      PH_COOKIE: begin
        if (b != magic[ck_pos]) begin
          push_outcome(ST_COOKIE);
          ended = 1'b1;
        end else if (ck_pos == 2'd3) begin
          ph = PH_CODE;
        end else begin
          ck_pos = ck_pos + 2'd1;
        end
      end
      PH_CODE: begin
        if (b == CODE_END) begin
          push_outcome(ST_OK);
          ended = 1'b1;
        end else if (b != CODE_PAD) begin
          opt_code = b;
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        data_left = b;
        data_idx  = 3'd0;
        gather    = 32'd0;
        if (b == 8'd0) begin
          store_option();
          ph = PH_CODE;
        end else begin
          ph = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_idx < 3'd4) begin
          gather = gather | (32'(b) << (24 - 8 * int'(data_idx)));
          data_idx = data_idx + 3'd1;
        end
        data_left = data_left - 8'd1;
        if (data_left == 8'd0) begin
          store_option();
          ph = PH_CODE;
        end
      end
      default: ended = 1'b1;  // no parse active, byte dropped
    endcase
    if (!ended && l) push_outcome(ST_NOEND);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40) begin
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  // one option area, mostly well formed, sometimes cut, restarted or broken
  task automatic gen_packet();
    logic [7:0] pkt[$];
    logic [7:0] code;
    logic [7:0] v;
    int kind;
    int sel;
    int len;
    int cut;
    int pos;
    int tail;
    bit with_last;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) begin
        put_byte(8'($urandom_range(255)), $urandom_range(15) == 0,
                 $urandom_range(3) == 0);
      end
      return;
    end
    for (int i = 0; i < 4; i++) pkt.push_back(magic[i]);
    repeat ($urandom_range(0, 6)) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        pkt.push_back(CODE_PAD);
      end else begin
        if (sel <= 2) code = CODE_MASK;
        else if (sel <= 4) code = CODE_GATEWAY;
        else if (sel <= 6) code = CODE_DNS;
        else code = 8'($urandom_range(1, 254));
        if ($urandom_range(39) == 0) len = $urandom_range(128, 255);
        else if (sel <= 6 && $urandom_range(1) == 1) len = 4;
        else len = $urandom_range(0, 10);
        pkt.push_back(code);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom_range(255)));
      end
    end
    pkt.push_back(CODE_END);
    cut = pkt.size() - 1;
    with_last = 1'b1;
    tail = 0;
    if (kind < 55) begin
      if ($urandom_range(4) == 0) begin
        with_last = 1'b0;
        tail = $urandom_range(1, 3);
      end
    end else if (kind < 72) begin
      cut = $urandom_range(0, pkt.size() - 2);
    end else if (kind < 82) begin
      pos = $urandom_range(3);
      v = 8'($urandom_range(255));
      while (v == magic[pos]) v = 8'($urandom_range(255));
      pkt[pos] = v;
    end else begin
      // abandoned area, the next first byte restarts parsing
      cut = $urandom_range(0, pkt.size() - 2);
      with_last = 1'b0;
    end
    for (int i = 0; i <= cut; i++) begin
      put_byte(pkt[i], i == 0, with_last && i == cut);
    end
    for (int i = 0; i < tail; i++) begin
      put_byte(8'($urandom_range(255)), 1'b0, i == tail - 1);
    end
  endtask

  task automatic wait_quiet();
    while (option_bytes_q.size() != 0 || in_tvalid || parse_outcomes.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (option_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_byte = option_bytes_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data_byte;
        in_tuser  <= next_byte.first_byte;
        in_tlast  <= next_byte.last_byte;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the parser backs up into its input
  initial begin
    wait (hold_phase);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // monitor: check results first, then predict from the byte taken this edge
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (parse_outcomes.size() == 0) begin
          report_mismatch("result with none pending", {30'd0, out_tuser}, 32'd0);
        end else begin
          dop_result_t want;
          want = parse_outcomes.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", {30'd0, out_tuser}, {30'd0, want.status});
          if (out_tdata[31:0] !== want.subnet_mask)
            report_mismatch("subnet_mask", out_tdata[31:0], want.subnet_mask);
          if (out_tdata[63:32] !== want.gateway_addr)
            report_mismatch("gateway_addr", out_tdata[63:32], want.gateway_addr);
          if (out_tdata[95:64] !== want.dns_addr)
            report_mismatch("dns_addr", out_tdata[95:64], want.dns_addr);
          if (out_tdata[98:96] !== want.seen_bits)
            report_mismatch("seen_bits", {29'd0, out_tdata[98:96]}, {29'd0, want.seen_bits});
          if (out_tdata[103:99] !== 5'd0)
            report_mismatch("tdata pad", {27'd0, out_tdata[103:99]}, 32'd0);
        end
      end
      if (in_tvalid && in_tready) begin
        follow_parser_byte(in_tdata, in_tuser, in_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int idle_set [4];
    int stall_set [4];
    int phase_start;
    idle_set  = '{0, 51, 0, 29};
    stall_set = '{0, 0, 51, 29};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      phase_start = bytes_queued;
      if (p == 0) begin
        // stray bytes before any area starts
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b1);
        // first and last on one byte: good cookie start, then bad cookie
        put_byte(8'd99, 1'b1, 1'b1);
        put_byte(8'h00, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++) put_byte(magic[i], i == 0, 1'b0);
        put_byte(CODE_PAD, 1'b0, 1'b0);
        // zero-length mask, short gateway, long dns
        put_byte(CODE_MASK, 1'b0, 1'b0);
        put_byte(8'd0, 1'b0, 1'b0);
        put_byte(CODE_GATEWAY, 1'b0, 1'b0);
        put_byte(8'd2, 1'b0, 1'b0);
        put_byte(8'hC0, 1'b0, 1'b0);
        put_byte(8'hA8, 1'b0, 1'b0);
        put_byte(CODE_DNS, 1'b0, 1'b0);
        put_byte(8'd5, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        put_byte(8'h01, 1'b0, 1'b0);
        put_byte(8'h80, 1'b0, 1'b0);
        put_byte(8'h7F, 1'b0, 1'b0);
        put_byte(8'hAA, 1'b0, 1'b0);
        put_byte(CODE_END, 1'b0, 1'b0);
        // area cut inside the cookie
        put_byte(8'd99, 1'b1, 1'b0);
        put_byte(8'd130, 1'b0, 1'b1);
        hold_phase = 1'b1;
      end
      while (bytes_queued - phase_start < PHASE_BYTES) gen_packet();
      wait_quiet();
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
